[rtl/core/flow_session_table_defines.svh]
// ----------------------------------------------------------------------------
// Flow session table assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset disable.
// ----------------------------------------------------------------------------
`ifndef FLOW_SESSION_TABLE_DEFINES_SVH
`define FLOW_SESSION_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define FST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FST_ASSERT(name, prop, msg)
`define FST_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[rtl/core/fst_pkg.sv]
// ----------------------------------------------------------------------------
// Flow session table package
// Sizes, codes, entry layout and state machine type.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int BUCKETS   = 1024;
  localparam int WAYS      = 4;
  localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int N_W       = $clog2(BUCKETS + 1);
  localparam int REM_W     = N_W + 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W     = $clog2(WAYS + 1);
  localparam int DIV_STEP  = 4;
  localparam int DIV_ITERS = 32 / DIV_STEP;
  localparam int DIV_CW    = $clog2(DIV_ITERS);

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_HIT     = 3'd1,
    ST_NEW     = 3'd2,
    ST_FULL    = 3'd3,
    ST_TICK    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    HM_XOR    = 2'd0,
    HM_XORSUM = 2'd1,
    HM_SUM    = 2'd2
  } hash_mode_e;

  typedef enum logic [1:0] {
    CFG_HASH_MODE    = 2'd0,
    CFG_BUCKET_COUNT = 2'd1,
    CFG_EXPIRE_TIME  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_DIV,
    S_READ,
    S_LOOKUP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] ips;
    logic [39:0] pp;
    logic        dir;
    logic [31:0] up_pkts;
    logic [31:0] up_bytes;
    logic [31:0] dn_pkts;
    logic [31:0] dn_bytes;
    logic [31:0] last_seen;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic logic is_private(input logic [31:0] ip);
    return ((ip & 32'hff000000) == 32'h0a000000) ||
           ((ip & 32'hffff0000) == 32'hc0a80000) ||
           ((ip & 32'hfff00000) == 32'hac100000);
  endfunction

endpackage

[rtl/core/fst_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module fst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[rtl/core/flow_session_table.sv]
// ----------------------------------------------------------------------------
// Flow session table
// Five-tuple session lookup and insert with per-bucket aging.
// ----------------------------------------------------------------------------
// After reset the table runs a clearing pass, one bucket row a cycle, and
// accepts no beat until it is done (configuration is taken as usual). A
// packet beat runs capture, hash, modulo reduction (four quotient bits a
// cycle against bucket_count), one row read of the bucket, compare and
// write-back of all ways, and the hand to the output register. Unknown beats
// go from capture to the hand; ticks skip hash and reduction. All ways of a
// bucket sit in one row of a single-port RAM, so one item is in work at a
// time; the result register lets the next beat in while a result waits.
`include "flow_session_table_defines.svh"

module flow_session_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic        is_ipv4_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] sport_i,
  input  logic [15:0] dport_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] pkt_len_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        direction_o,
  output logic [9:0]  bucket_o,
  output logic [31:0] up_pkts_o,
  output logic [31:0] up_bytes_o,
  output logic [31:0] dn_pkts_o,
  output logic [31:0] dn_bytes_o,
  output logic [2:0]  expired_count_o
);

  fst_pkg::state_e state_q, state_d;

  logic [1:0]  hash_mode_q;
  logic [10:0] bucket_count_q;
  logic [31:0] expire_time_q;
  logic [fst_pkg::N_W-1:0] n_eff;

  logic [fst_pkg::BKT_W-1:0]  clr_cnt_q;
  logic [fst_pkg::BKT_W-1:0]  age_q;
  logic [fst_pkg::DIV_CW-1:0] div_cnt_q;

  logic        op_q, swap_q;
  logic [31:0] ip0_q, ip1_q, now_q;
  logic [15:0] p0_q, p1_q, len_q;
  logic [7:0]  proto_q;
  logic [31:0] div_q;
  logic [fst_pkg::REM_W-1:0] rem_q, rem_d;
  logic [fst_pkg::BKT_W-1:0] bkt_q, rd_addr, tick_b;

  logic        ram_we;
  logic [fst_pkg::BKT_W-1:0] ram_addr;
  logic [fst_pkg::ROW_W-1:0] ram_wdata, ram_rdata;
  fst_pkg::row_t row_rd, row_wr;

  logic in_fire, unknown, out_load;
  logic [31:0] hash;

  logic        res_dir_q;
  logic [2:0]  res_status_q, res_exp_q;
  logic [31:0] res_up_pkts_q, res_up_bytes_q, res_dn_pkts_q, res_dn_bytes_q;
  logic        out_valid_q;

  // lookup results
  logic        found, freefound, sdir, pdir;
  logic [fst_pkg::WAY_W-1:0] hit_w, free_w, sel_w;
  logic [fst_pkg::CNT_W-1:0] removed;
  fst_pkg::entry_t upd;

  // effective bucket count: 0 acts as 1, large values clamp
  always_comb begin
    if (bucket_count_q == '0) begin
      n_eff = fst_pkg::N_W'(1);
    end else if ({1'b0, bucket_count_q} > 12'(fst_pkg::BUCKETS)) begin
      n_eff = fst_pkg::N_W'(fst_pkg::BUCKETS);
    end else begin
      n_eff = fst_pkg::N_W'(bucket_count_q);
    end
  end

  assign in_stall_o = (state_q != fst_pkg::S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign unknown    = !is_ipv4_i || !((protocol_i == fst_pkg::PROTO_ICMP) ||
                      (protocol_i == fst_pkg::PROTO_TCP) ||
                      (protocol_i == fst_pkg::PROTO_UDP));
  assign out_load   = (state_q == fst_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  assign tick_b  = ({1'b0, age_q} < (fst_pkg::N_W + 1)'(n_eff)) ? age_q : '0;
  assign rd_addr = op_q ? tick_b : rem_q[fst_pkg::BKT_W-1:0];

  // hash of the ordered tuple
  always_comb begin
    case (fst_pkg::hash_mode_e'(hash_mode_q))
      fst_pkg::HM_XORSUM: hash = (ip0_q ^ ip1_q) + {16'b0, p0_q ^ p1_q};
      fst_pkg::HM_SUM:    hash = ip0_q + ip1_q + {16'b0, p0_q} + {16'b0, p1_q};
      default:            hash = ip0_q ^ ip1_q ^ {16'b0, p0_q ^ p1_q};
    endcase
  end

  // restoring reduction, four dividend bits a cycle
  always_comb begin
    rem_d = rem_q;
    for (int i = 0; i < fst_pkg::DIV_STEP; i++) begin
      rem_d = {rem_d[fst_pkg::REM_W-2:0], div_q[31-i]};
      if (rem_d >= fst_pkg::REM_W'(n_eff)) begin
        rem_d = rem_d - fst_pkg::REM_W'(n_eff);
      end
    end
  end

  assign row_rd = fst_pkg::row_t'(ram_rdata);

  // way search, insert and aging on the bucket row
  always_comb begin
    found     = 1'b0;
    freefound = 1'b0;
    hit_w     = '0;
    free_w    = '0;
    removed   = '0;
    row_wr    = row_rd;
    for (int w = 0; w < fst_pkg::WAYS; w++) begin
      if (row_rd[w].valid) begin
        if (!found && row_rd[w].ips == {ip0_q, ip1_q} &&
            row_rd[w].pp == {p0_q, p1_q, proto_q}) begin
          found = 1'b1;
          hit_w = fst_pkg::WAY_W'(w);
        end
        if ((now_q - row_rd[w].last_seen) >= expire_time_q) begin
          removed = removed + fst_pkg::CNT_W'(1);
          if (op_q) begin
            row_wr[w].valid = 1'b0;
          end
        end
      end else if (!freefound) begin
        freefound = 1'b1;
        free_w    = fst_pkg::WAY_W'(w);
      end
    end

    if (fst_pkg::is_private(ip0_q) && !fst_pkg::is_private(ip1_q)) begin
      sdir = 1'b0;
    end else if (fst_pkg::is_private(ip1_q) && !fst_pkg::is_private(ip0_q)) begin
      sdir = 1'b1;
    end else begin
      sdir = (p0_q < p1_q);
    end

    sel_w = found ? hit_w : free_w;
    if (found) begin
      upd = row_rd[hit_w];
    end else begin
      upd       = '0;
      upd.valid = 1'b1;
      upd.ips   = {ip0_q, ip1_q};
      upd.pp    = {p0_q, p1_q, proto_q};
      upd.dir   = sdir;
    end
    pdir = upd.dir ^ swap_q;
    if (!pdir) begin
      upd.up_pkts  = upd.up_pkts + 32'd1;
      upd.up_bytes = upd.up_bytes + {16'b0, len_q};
    end else begin
      upd.dn_pkts  = upd.dn_pkts + 32'd1;
      upd.dn_bytes = upd.dn_bytes + {16'b0, len_q};
    end
    upd.last_seen = now_q;
    if (!op_q) begin
      row_wr[sel_w] = upd;
    end
  end

  // RAM port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = bkt_q;
    ram_wdata = fst_pkg::ROW_W'(row_wr);
    case (state_q)
      fst_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
      end
      fst_pkg::S_READ: begin
        ram_addr = rd_addr;
      end
      fst_pkg::S_LOOKUP: begin
        ram_we = op_q || found || freefound;
      end
      default: begin
        ram_addr = bkt_q;
      end
    endcase
  end

  fst_ram #(
    .WIDTH (fst_pkg::ROW_W),
    .DEPTH (fst_pkg::BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fst_pkg::S_CLEAR: begin
        if (clr_cnt_q == fst_pkg::BKT_W'(fst_pkg::BUCKETS - 1)) state_d = fst_pkg::S_IDLE;
      end
      fst_pkg::S_IDLE: begin
        if (in_fire) begin
          if (op_i) begin
            state_d = fst_pkg::S_READ;
          end else if (unknown) begin
            state_d = fst_pkg::S_DONE;
          end else begin
            state_d = fst_pkg::S_HASH;
          end
        end
      end
      fst_pkg::S_HASH:   state_d = fst_pkg::S_DIV;
      fst_pkg::S_DIV: begin
        if (div_cnt_q == fst_pkg::DIV_CW'(fst_pkg::DIV_ITERS - 1)) state_d = fst_pkg::S_READ;
      end
      fst_pkg::S_READ:   state_d = fst_pkg::S_LOOKUP;
      fst_pkg::S_LOOKUP: state_d = fst_pkg::S_DONE;
      fst_pkg::S_DONE: begin
        if (out_load) state_d = fst_pkg::S_IDLE;
      end
      default: state_d = fst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fst_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mode_q    <= '0;
      bucket_count_q <= 11'd1024;
      expire_time_q  <= 32'd60;
      clr_cnt_q      <= '0;
      age_q          <= '0;
      div_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (fst_pkg::cfg_idx_e'(cfg_index_i))
          fst_pkg::CFG_HASH_MODE:    hash_mode_q    <= cfg_data_i[1:0];
          fst_pkg::CFG_BUCKET_COUNT: bucket_count_q <= cfg_data_i[10:0];
          fst_pkg::CFG_EXPIRE_TIME:  expire_time_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == fst_pkg::S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (state_q == fst_pkg::S_HASH) div_cnt_q <= '0;
      else if (state_q == fst_pkg::S_DIV) div_cnt_q <= div_cnt_q + 1'b1;
      if (state_q == fst_pkg::S_LOOKUP && op_q) begin
        age_q <= (({1'b0, bkt_q} + 1'b1) >= (fst_pkg::BKT_W + 1)'(n_eff)) ?
                 '0 : bkt_q + 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_i;
      proto_q <= protocol_i;
      len_q   <= pkt_len_i;
      now_q   <= now_i;
      // lower address first
      if (src_ip_i > dst_ip_i) begin
        ip0_q <= dst_ip_i;  ip1_q <= src_ip_i;
        p0_q  <= dport_i;   p1_q  <= sport_i;
        swap_q <= 1'b1;
      end else begin
        ip0_q <= src_ip_i;  ip1_q <= dst_ip_i;
        p0_q  <= sport_i;   p1_q  <= dport_i;
        swap_q <= 1'b0;
      end
      res_status_q   <= fst_pkg::ST_UNKNOWN;
      res_dir_q      <= 1'b0;
      res_exp_q      <= '0;
      res_up_pkts_q  <= '0;
      res_up_bytes_q <= '0;
      res_dn_pkts_q  <= '0;
      res_dn_bytes_q <= '0;
      bkt_q          <= '0;
    end
    if (state_q == fst_pkg::S_HASH) begin
      div_q <= hash;
      rem_q <= '0;
    end else if (state_q == fst_pkg::S_DIV) begin
      div_q <= div_q << fst_pkg::DIV_STEP;
      rem_q <= rem_d;
    end
    if (state_q == fst_pkg::S_READ) bkt_q <= rd_addr;
    if (state_q == fst_pkg::S_LOOKUP) begin
      if (op_q) begin
        res_status_q <= fst_pkg::ST_TICK;
        res_exp_q    <= (removed > fst_pkg::CNT_W'(7)) ? 3'd7 : 3'(removed);
      end else if (found || freefound) begin
        res_status_q   <= found ? fst_pkg::ST_HIT : fst_pkg::ST_NEW;
        res_dir_q      <= pdir;
        res_up_pkts_q  <= upd.up_pkts;
        res_up_bytes_q <= upd.up_bytes;
        res_dn_pkts_q  <= upd.dn_pkts;
        res_dn_bytes_q <= upd.dn_bytes;
      end else begin
        res_status_q <= fst_pkg::ST_FULL;
      end
    end
    if (out_load) begin
      status_o        <= res_status_q;
      direction_o     <= res_dir_q;
      bucket_o        <= 10'(bkt_q);
      up_pkts_o       <= res_up_pkts_q;
      up_bytes_o      <= res_up_bytes_q;
      dn_pkts_o       <= res_dn_pkts_q;
      dn_bytes_o      <= res_dn_bytes_q;
      expired_count_o <= res_exp_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `FST_ASSERT_ALWAYS(a_clear_blocks_input,
    state_q == fst_pkg::S_CLEAR |-> in_stall_o, "beat during clear")
  `FST_ASSERT(a_result_from_done,
    $rose(out_valid_q) |-> $past(state_q == fst_pkg::S_DONE), "stray result")
  `FST_ASSERT(a_rem_in_range,
    (state_q == fst_pkg::S_READ) && !op_q |-> rem_q < fst_pkg::REM_W'(n_eff), "bad remainder")
  `FST_ASSERT(a_write_state,
    ram_we |-> (state_q == fst_pkg::S_CLEAR) || (state_q == fst_pkg::S_LOOKUP), "stray row write")

endmodule
